FILE: rtl/core/fss_pkg.sv
`default_nettype none
package fss_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PAREN  = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_SLINE  = 2'd3
  } skip_mode_t;

  typedef struct packed {
    logic       in_string;
    skip_mode_t skip_mode;
    logic       space_run;
  } fss_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/fss_step.sv
`default_nettype none
module fss_step (
  input  wire logic [7:0]         byte_i,
  input  wire fss_pkg::fss_state_t st_i,
  output fss_pkg::fss_state_t     st_o,
  output logic                    emit_o,
  output logic [7:0]              byte_o
);
  import fss_pkg::*;

  logic cont;
  logic blank;

  assign blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_CR) ||
                 (byte_i == CH_LF) || (byte_i == CH_NUL);

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    byte_o = byte_i;
    cont   = 1'b0;

    unique case (st_i.skip_mode)
      MODE_PAREN: begin
        if (byte_i == CH_RPAREN) begin
          st_o.skip_mode = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (byte_i == CH_LF) begin
          st_o.skip_mode = MODE_NORMAL;
          cont           = 1'b1;
        end
      end
      MODE_SLINE: begin
        if (byte_i == CH_QUOTE) begin
          st_o.in_string = ~st_i.in_string;
        end else if (byte_i == CH_LF) begin
          // A string-line comment that ends outside a string leaves a run open.
          st_o.skip_mode = MODE_NORMAL;
          st_o.space_run = ~st_i.in_string;
          cont           = 1'b1;
        end
      end
      default: begin
        cont = 1'b1;
      end
    endcase

    // The terminating newline of a line comment is then treated as an ordinary byte.
    if (cont) begin
      priority if (byte_i == CH_QUOTE) begin
        st_o.in_string = ~st_o.in_string;
        st_o.space_run = 1'b0;
        emit_o         = 1'b1;
      end else if (!st_o.in_string && byte_i == CH_LPAREN) begin
        emit_o         = ~st_o.space_run;
        byte_o         = CH_SPACE;
        st_o.skip_mode = MODE_PAREN;
        st_o.space_run = 1'b1;
      end else if (byte_i == CH_BSLASH) begin
        emit_o = ~st_o.space_run;
        byte_o = CH_SPACE;
        if (st_o.in_string) begin
          st_o.skip_mode = MODE_SLINE;
        end else begin
          st_o.skip_mode = MODE_LINE;
          st_o.space_run = 1'b1;
        end
      end else if (!st_o.in_string && blank) begin
        emit_o         = ~st_o.space_run;
        byte_o         = CH_SPACE;
        st_o.space_run = 1'b1;
      end else begin
        st_o.space_run = 1'b0;
        emit_o         = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/forth_source_squeezer_top.sv
// Source squeezer for Forth-like text: one byte word in, zero or one byte word out.
// Input channel in_valid/in_ready/in_byte, result channel out_valid/out_ready/out_byte.
// An accepted word is held in an input register; once the output register is free it
// is filtered against the quote, comment and whitespace-run flags, and any result is
// loaded into the output register.
// One word is accepted per cycle while the receiver takes results; the single
// combinational filter step between the two registers sets that rate.
// Comments and runs of whitespace outside strings come out as one space (0x20);
// words that produce nothing are simply dropped.
// When the receiver stalls, the output register holds its word, the input register
// fills behind it and in_ready then falls until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers and returns the filter to
// the state outside any string, comment or whitespace run.
`default_nettype none
module forth_source_squeezer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte
);
  import fss_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  fss_state_t st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;

  fss_state_t step_st;
  logic       step_emit;
  logic [7:0] step_byte;
  logic       adv;

  fss_step u_step (
    .byte_i (s1_byte_r),
    .st_i   (st_r),
    .st_o   (step_st),
    .emit_o (step_emit),
    .byte_o (step_byte)
  );

  // The held word moves on only when the output register is free this cycle.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt  = in_valid || (s1_valid_r && !adv);
    st_nxt        = adv ? step_st : st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (adv && step_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{in_string: 1'b0, skip_mode: MODE_NORMAL, space_run: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
    if (adv && step_emit) begin
      out_byte_r <= step_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

`ifndef SYNTHESIS
  a_comment_opens_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.skip_mode == MODE_PAREN || st_r.skip_mode == MODE_LINE) |-> st_r.space_run)
    else $error("comment open without an open whitespace run");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("held word lost while output stalled");

  a_paren_only_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_emit && step_byte == CH_LPAREN && st_r.skip_mode == MODE_NORMAL)
      |-> st_r.in_string)
    else $error("parenthesis passed through outside a string");
`endif

endmodule
`default_nettype wire
